// ----- rtl/bfgg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfgg_pkg: shared types and constants
// Payload structs, operation and status codes, register indexes and the
// controller/datapath command bundle.
// ----------------------------------------------------------------------------
package bfgg_pkg;

  localparam int unsigned DEF_MAX_CELLS = 1024;
  localparam int unsigned DEF_BAND_COLS = 16;
  localparam int unsigned DEF_MAX_ROWS  = 512;

  localparam int unsigned BIN_W  = 24;
  localparam int unsigned GRAD_W = 48;
  localparam int unsigned DIV_W  = 10;

  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_SCAN  = 3'd1;
  localparam logic [2:0] OP_FIELD = 3'd2;
  localparam logic [2:0] OP_ACC   = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_OUTSIDE   = 2'd1;
  localparam logic [1:0] ST_NOT_OWNED = 2'd2;

  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_CAP   = 2'd1;
  localparam logic [1:0] REG_FIRST = 2'd2;
  localparam logic [1:0] REG_OWNED = 2'd3;

  typedef struct packed {
    logic [2:0]         operation;
    logic [31:0]        cell_id;
    logic [23:0]        global_bin;
    logic [31:0]        record_weight;
    logic [3:0]         band_column;
    logic [8:0]         band_row;
    logic signed [31:0] field_x;
    logic signed [31:0] field_y;
    logic [9:0]         slot;
  } in_item_t;

  typedef struct packed {
    logic [23:0]        band_start;
    logic [4:0]         band_width;
    logic signed [47:0] grad_x;
    logic signed [47:0] grad_y;
    logic [1:0]         status;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item
    logic div_start;  // launch the column divide
    logic div_step;   // one quotient bit
    logic clr_step;   // clear one gradient entry
    logic clr_reset;  // clear span, restart clear counter
    logic scan_upd;   // fold column into span
    logic field_wr;   // write field store
    logic acc_rd;     // read field and gradient entries
    logic acc_mul;    // register products
    logic acc_wr;     // write back gradient
    logic rd_rd;      // read gradient for a read item
    logic emit;       // launch the result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic clr_done;
  } dp_stat_t;

endpackage

// ----- rtl/bfgg_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfgg_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module bfgg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ----- rtl/bfgg_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfgg_datapath: registers, divider, band logic, field and gradient stores
// Executes controller commands; reports divide and clear completion.
// ----------------------------------------------------------------------------
module bfgg_datapath #(
  parameter int unsigned MAX_CELLS = 1024,
  parameter int unsigned BAND_COLS = 16,
  parameter int unsigned MAX_ROWS  = 512
) (
  input  logic                clk,
  input  logic                rst,
  input  bfgg_pkg::in_item_t  item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [31:0]         cfg_data,
  input  bfgg_pkg::dp_cmd_t   cmd,
  output bfgg_pkg::dp_stat_t  stat,
  output bfgg_pkg::out_item_t res
);
  import bfgg_pkg::*;

  localparam int unsigned CELL_AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int unsigned COL_AW  = (BAND_COLS > 1) ? $clog2(BAND_COLS) : 1;
  localparam int unsigned ROW_AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned FLD_D   = (1 << COL_AW) * (1 << ROW_AW);
  localparam int unsigned FLD_AW  = COL_AW + ROW_AW;
  localparam int unsigned CNT_W   = $clog2(MAX_CELLS + 1);
  localparam int unsigned BW_W    = $clog2(BAND_COLS + 1);
  localparam int unsigned RW_W    = $clog2(MAX_ROWS + 1);
  localparam logic signed [GRAD_W:0] SAT_MAX = {2'b00, {(GRAD_W-1){1'b1}}};
  localparam logic signed [GRAD_W:0] SAT_MIN = {2'b11, {(GRAD_W-1){1'b0}}};

  // configuration registers
  logic [9:0]  reg_rows;
  logic [4:0]  reg_cap;
  logic [31:0] reg_first;
  logic [10:0] reg_owned;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_rows  <= 10'd512;
      reg_cap   <= 5'd16;
      reg_first <= '0;
      reg_owned <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ROWS:  reg_rows  <= cfg_data[9:0];
        REG_CAP:   reg_cap   <= cfg_data[4:0];
        REG_FIRST: reg_first <= cfg_data;
        REG_OWNED: reg_owned <= cfg_data[10:0];
        default:   ;
      endcase
    end
  end

  // clamped register values
  logic [RW_W-1:0]  rows_eff;
  logic [BW_W-1:0]  cap_eff;
  logic [CNT_W-1:0] owned_eff;
  always_comb begin
    if (reg_rows == '0) rows_eff = RW_W'(1);
    else if ({22'd0, reg_rows} > 32'(MAX_ROWS)) rows_eff = RW_W'(MAX_ROWS);
    else rows_eff = RW_W'(reg_rows);
    if (reg_cap == '0) cap_eff = BW_W'(1);
    else if ({27'd0, reg_cap} > 32'(BAND_COLS)) cap_eff = BW_W'(BAND_COLS);
    else cap_eff = BW_W'(reg_cap);
    if (reg_owned == '0) owned_eff = CNT_W'(1);
    else if ({21'd0, reg_owned} > 32'(MAX_CELLS)) owned_eff = CNT_W'(MAX_CELLS);
    else owned_eff = CNT_W'(reg_owned);
  end

  in_item_t it;
  always_ff @(posedge clk) begin
    if (cmd.load) it <= item;
  end

  // restoring divider: one quotient bit a cycle
  logic [BIN_W-1:0] quo;
  logic [DIV_W:0]   rem;
  logic [4:0]       div_cnt;
  logic [DIV_W+1:0] trial;
  assign trial = {rem, quo[BIN_W-1]} - {2'b00, DIV_W'(rows_eff)};
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      quo <= it.global_bin;
      rem <= '0;
      div_cnt <= 5'(BIN_W);
    end else if (cmd.div_step && div_cnt != '0) begin
      if (!trial[DIV_W+1]) begin
        rem <= trial[DIV_W:0];
        quo <= {quo[BIN_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DIV_W-1:0], quo[BIN_W-1]};
        quo <= {quo[BIN_W-2:0], 1'b0};
      end
      div_cnt <= div_cnt - 5'd1;
    end
  end

  // column span and band
  logic [BIN_W-1:0] min_col, max_col, bstart, bdiff;
  logic [BW_W-1:0]  bwidth;
  always_comb begin
    bdiff = max_col - min_col;
    if (min_col > max_col) begin
      bstart = '0;
      bwidth = BW_W'(1);
    end else begin
      bstart = min_col;
      if (bdiff >= BIN_W'(cap_eff)) bwidth = cap_eff;
      else bwidth = BW_W'(bdiff + BIN_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_reset) begin
      min_col <= '1;
      max_col <= '0;
    end else if (cmd.scan_upd) begin
      if (quo < min_col) min_col <= quo;
      if (quo > max_col) max_col <= quo;
    end
  end

  // accumulate checks (valid once divide finishes)
  logic [BIN_W-1:0] lc;
  logic [31:0]      loc;
  logic             outside, not_owned;
  assign lc        = quo - bstart;
  assign outside   = (quo < bstart) || (lc >= BIN_W'(bwidth));
  assign loc       = it.cell_id - reg_first;
  assign not_owned = (loc >= 32'(owned_eff));

  // clear sweep
  logic [CNT_W-1:0] clr_cnt;
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_reset) clr_cnt <= '0;
    else if (cmd.clr_step && clr_cnt != CNT_W'(MAX_CELLS)) clr_cnt <= clr_cnt + CNT_W'(1);
  end

  assign stat = '{div_done: (div_cnt == '0), clr_done: (clr_cnt == CNT_W'(MAX_CELLS))};

  // field store
  logic              fld_we;
  logic [FLD_AW-1:0] fld_addr;
  logic [31:0]       fx_q, fy_q;
  always_comb begin
    fld_we = 1'b0;
    if (cmd.field_wr) begin
      fld_we = ({28'd0, it.band_column} < 32'(BAND_COLS)) &&
               ({23'd0, it.band_row} < 32'(MAX_ROWS));
      fld_addr = {COL_AW'(it.band_column), ROW_AW'(it.band_row)};
    end else begin
      fld_addr = {COL_AW'(lc), ROW_AW'(rem)};
    end
  end

  bfgg_ram #(.WIDTH(32), .DEPTH(FLD_D)) u_fx (
    .clk(clk), .we(fld_we), .addr(fld_addr), .wdata(it.field_x), .rdata(fx_q));
  bfgg_ram #(.WIDTH(32), .DEPTH(FLD_D)) u_fy (
    .clk(clk), .we(fld_we), .addr(fld_addr), .wdata(it.field_y), .rdata(fy_q));

  // gradient store
  logic               g_we;
  logic [CELL_AW-1:0] g_addr;
  logic [GRAD_W-1:0]  gx_w, gy_w, gx_q, gy_q;
  logic signed [GRAD_W:0] sx, sy;
  logic signed [64:0] px, py;
  logic signed [GRAD_W-1:0] shx, shy;

  always_ff @(posedge clk) begin
    if (cmd.acc_mul) begin
      px <= $signed({33'd0, it.record_weight}) * $signed({{33{fx_q[31]}}, fx_q});
      py <= $signed({33'd0, it.record_weight}) * $signed({{33{fy_q[31]}}, fy_q});
    end
  end

  // product fits in 64 bits; shifted value fits 48
  assign shx = GRAD_W'(px >>> 16);
  assign shy = GRAD_W'(py >>> 16);
  assign sx  = $signed({gx_q[GRAD_W-1], gx_q}) + $signed({shx[GRAD_W-1], shx});
  assign sy  = $signed({gy_q[GRAD_W-1], gy_q}) + $signed({shy[GRAD_W-1], shy});

  always_comb begin
    g_we = 1'b0;
    gx_w = '0;
    gy_w = '0;
    g_addr = CELL_AW'(loc);
    if (cmd.clr_step) begin
      g_we = 1'b1;
      g_addr = CELL_AW'(clr_cnt);
    end else if (cmd.acc_wr) begin
      g_we = !outside && !not_owned;
      gx_w = (sx > SAT_MAX) ? GRAD_W'(SAT_MAX) : (sx < SAT_MIN) ? GRAD_W'(SAT_MIN) : GRAD_W'(sx);
      gy_w = (sy > SAT_MAX) ? GRAD_W'(SAT_MAX) : (sy < SAT_MIN) ? GRAD_W'(SAT_MIN) : GRAD_W'(sy);
    end else if (cmd.rd_rd) begin
      g_addr = CELL_AW'(it.slot);
    end
  end

  bfgg_ram #(.WIDTH(GRAD_W), .DEPTH(1 << CELL_AW)) u_gx (
    .clk(clk), .we(g_we), .addr(g_addr), .wdata(gx_w), .rdata(gx_q));
  bfgg_ram #(.WIDTH(GRAD_W), .DEPTH(1 << CELL_AW)) u_gy (
    .clk(clk), .we(g_we), .addr(g_addr), .wdata(gy_w), .rdata(gy_q));

  // result
  logic slot_ok;
  assign slot_ok = ({22'd0, it.slot} < 32'(owned_eff));
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res.band_start <= bstart;
      res.band_width <= 5'(bwidth);
      res.grad_x <= '0;
      res.grad_y <= '0;
      res.status <= ST_DONE;
      if (it.operation == OP_ACC) begin
        if (outside) res.status <= ST_OUTSIDE;
        else if (not_owned) res.status <= ST_NOT_OWNED;
      end else if (it.operation == OP_READ) begin
        if (slot_ok) begin
          res.grad_x <= gx_q;
          res.grad_y <= gy_q;
        end else begin
          res.status <= ST_NOT_OWNED;
        end
      end
    end
  end
endmodule

// ----- rtl/bfgg_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfgg_ctrl: sequencer for one item at a time
// Walks each operation through its datapath steps and raises done.
// ----------------------------------------------------------------------------
module bfgg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [2:0]          operation,
  input  bfgg_pkg::dp_stat_t  stat,
  output bfgg_pkg::dp_cmd_t   cmd,
  output logic                busy,
  output logic                done
);
  import bfgg_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_DIV, S_ACC_RD, S_ACC_MUL, S_ACC_WR,
    S_RD, S_EMIT, S_DONE
  } state_t;

  state_t     state;
  logic [2:0] op;
  logic       sweep_init;  // sweep after reset: no result at its end

  always_comb begin
    cmd = '0;
    cmd.load      = start && !busy;
    cmd.clr_step  = (state == S_CLEAR) && !stat.clr_done;
    cmd.div_start = (state == S_DISPATCH) && (op == OP_SCAN || op == OP_ACC);
    cmd.clr_reset = (state == S_DISPATCH) && (op == OP_START);
    cmd.field_wr  = (state == S_DISPATCH) && (op == OP_FIELD);
    cmd.rd_rd     = (state == S_DISPATCH) && (op == OP_READ);
    cmd.div_step  = (state == S_DIV);
    cmd.scan_upd  = (state == S_DIV) && stat.div_done && (op == OP_SCAN);
    cmd.acc_rd    = (state == S_ACC_RD);
    cmd.acc_mul   = (state == S_ACC_MUL);
    cmd.acc_wr    = (state == S_ACC_WR);
    cmd.emit      = (state == S_EMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      busy       <= 1'b1;
      done       <= 1'b0;
      op         <= OP_START;
      sweep_init <= 1'b1;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: if (stat.clr_done) begin
          if (sweep_init) begin
            sweep_init <= 1'b0;
            busy       <= 1'b0;
            state      <= S_IDLE;
          end else begin
            state <= S_EMIT;
          end
        end
        S_IDLE: if (start) begin
          op    <= operation;
          busy  <= 1'b1;
          state <= S_DISPATCH;
        end
        S_DISPATCH: begin
          case (op)
            OP_SCAN, OP_ACC: state <= S_DIV;
            OP_START:        state <= S_CLEAR;
            default:         state <= S_EMIT;
          endcase
        end
        S_DIV: if (stat.div_done) begin
          state <= (op == OP_ACC) ? S_ACC_RD : S_EMIT;
        end
        S_ACC_RD:  state <= S_ACC_MUL;
        S_ACC_MUL: state <= S_ACC_WR;
        S_ACC_WR:  state <= S_EMIT;
        S_RD:      state <= S_EMIT;
        S_EMIT:    state <= S_DONE;
        S_DONE: begin
          done  <= 1'b1;
          busy  <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/banded_field_gradient_gather_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banded_field_gradient_gather_core: band gradient gather engine
// Tracks the scanned column band, holds a banded field store and gathers
// weighted field values into saturating per-cell gradients.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// command   in         start & !busy           cmd (in_item_t)
// result    out        done strobe, 1 cycle    result (out_item_t)
// config    in         cfg_valid & cfg_ready   cfg_index, cfg_data
//
// Write field and read go from dispatch straight to emit. Scan and accumulate
// run the 24-step bit-serial column divide; accumulate then adds field read,
// multiply and gradient read-modify-write on single-port memories.
// Start also sweeps the gradient store, one entry a cycle, before its result.
// After reset the same sweep runs with busy high. done pulses one cycle; the
// receiver cannot stall. cfg_ready is always high.
// ----------------------------------------------------------------------------
module banded_field_gradient_gather_core #(
  parameter int unsigned MAX_CELLS = bfgg_pkg::DEF_MAX_CELLS,
  parameter int unsigned BAND_COLS = bfgg_pkg::DEF_BAND_COLS,
  parameter int unsigned MAX_ROWS  = bfgg_pkg::DEF_MAX_ROWS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  bfgg_pkg::in_item_t  cmd,
  output logic                done,
  output bfgg_pkg::out_item_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import bfgg_pkg::*;

  dp_cmd_t  dcmd;
  dp_stat_t dstat;

  assign cfg_ready = 1'b1;

  bfgg_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .operation(cmd.operation),
    .stat(dstat), .cmd(dcmd), .busy(busy), .done(done));

  bfgg_datapath #(
    .MAX_CELLS(MAX_CELLS), .BAND_COLS(BAND_COLS), .MAX_ROWS(MAX_ROWS)
  ) u_dp (
    .clk(clk), .rst(rst), .item(cmd), .cfg_we(cfg_valid && cfg_ready),
    .cfg_idx(cfg_index), .cfg_data(cfg_data), .cmd(dcmd), .stat(dstat),
    .res(result));
endmodule

// ----- rtl/bfgg_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfgg_checker: port-level checks for the gather core
// Transaction ordering and result sanity seen from the ports.
// ----------------------------------------------------------------------------
module bfgg_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input bfgg_pkg::out_item_t result
);
  import bfgg_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted transaction did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one cycle");

  a_width: assert property (@(posedge clk) disable iff (rst)
    done |-> result.band_width != 5'd0 && result.status != 2'd3)
    else $error("bad band width or status");

  a_grad_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_DONE |-> result.grad_x == '0 && result.grad_y == '0)
    else $error("gradient on skipped transaction");
endmodule

bind banded_field_gradient_gather_core bfgg_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result));
